// File: hw/rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps

package i2cbm_pkg;

    // Width of the delay and poll counters; delays saturate at its maximum.
    localparam int CountW = 8;
    localparam logic [15:0] CntMax16 = 16'((32'd1 << CountW) - 32'd1);

    typedef logic [CountW-1:0] t_cnt;

    // Classified command codes carried from the front to the back.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // One tick word as queued between front and back.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_word;

    // One result word.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_res;

    // Clamp an 8-bit register value to the counter range.
    function automatic t_cnt sat_cnt(input logic [7:0] v);
        logic [15:0] w;
        w = {8'd0, v};
        if (w > CntMax16) begin
            return '1;
        end
        return t_cnt'(w);
    endfunction

endpackage

// File: hw/rtl/i2cbm_front.sv
`timescale 1ns / 1ps

module i2cbm_front
    import i2cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_write_data,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    output t_word      o_word,
    output logic       o_word_valid,
    input  logic       i_word_take
);

    t_word      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_word      w_in;
    logic       w_wr, w_rd;

    // Classify: unknown kinds become plain ticks.
    always_comb begin
        w_in.write_data = i_write_data;
        w_in.send_ack   = i_send_ack;
        w_in.sda_in     = i_sda_in;
        case (i_kind)
            3'd1:    w_in.cmd = CMD_START;
            3'd2:    w_in.cmd = CMD_STOP;
            3'd3:    w_in.cmd = CMD_WRITE;
            3'd4:    w_in.cmd = CMD_WAIT;
            3'd5:    w_in.cmd = CMD_READ;
            default: w_in.cmd = CMD_TICK;
        endcase
    end

    assign full         = (r_cnt == 2'd2);
    assign w_wr         = push && !full;
    assign o_word_valid = (r_cnt != 2'd0);
    assign w_rd         = i_word_take && o_word_valid;
    assign o_word       = r_mem[r_rp];

    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_in;
        end
    end

endmodule

// File: hw/rtl/i2cbm_back.sv
`timescale 1ns / 1ps

module i2cbm_back
    import i2cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_half,
    input  logic [7:0] i_ack_lim,
    input  t_word      i_word,
    input  logic       i_word_valid,
    output logic       o_word_take,
    input  logic       pop,
    output logic       empty,
    output t_res       o_res
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_S0    = 4'd1;
    localparam logic [3:0] PH_S1    = 4'd2;
    localparam logic [3:0] PH_P0    = 4'd3;
    localparam logic [3:0] PH_P1    = 4'd4;
    localparam logic [3:0] PH_WL    = 4'd5;
    localparam logic [3:0] PH_WH    = 4'd6;
    localparam logic [3:0] PH_A0    = 4'd7;
    localparam logic [3:0] PH_A1    = 4'd8;
    localparam logic [3:0] PH_APOLL = 4'd9;
    localparam logic [3:0] PH_RL    = 4'd10;
    localparam logic [3:0] PH_RH    = 4'd11;
    localparam logic [3:0] PH_K0    = 4'd12;
    localparam logic [3:0] PH_K1    = 4'd13;

    logic [3:0] r_phase, n_phase;
    t_cnt       r_dly, n_dly;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    t_cnt       r_poll, n_poll;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_err, n_err;
    logic       r_ackc, n_ackc;
    logic [7:0] r_last, n_last;
    logic       w_done;

    t_cnt       w_dly_load;
    t_cnt       w_lim;
    t_cnt       w_dly_dec;

    t_res       r_q [2];
    logic       r_qwp, r_qrp;
    logic [1:0] r_qcnt, n_qcnt;
    logic       w_qfull, w_qrd;
    t_res       w_res;

    always_comb begin
        w_dly_load = sat_cnt(i_half);
        if (w_dly_load == '0) begin
            w_dly_load = t_cnt'(1);
        end
        w_lim     = sat_cnt(i_ack_lim);
        w_dly_dec = (r_dly != '0) ? r_dly - t_cnt'(1) : '0;
    end

    assign w_qfull     = (r_qcnt == 2'd2);
    assign o_word_take = i_word_valid && !w_qfull;

    // One bus tick per word.
    always_comb begin
        n_phase = r_phase;
        n_dly   = r_dly;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_err   = r_err;
        n_ackc  = r_ackc;
        n_last  = r_last;
        w_done  = 1'b0;
        if (r_phase == PH_IDLE) begin
            case (i_word.cmd)
                CMD_START: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_dly = w_dly_load; n_phase = PH_S0;
                end
                CMD_STOP: begin
                    n_scl = 1'b0; n_sda = 1'b0;
                    n_dly = w_dly_load; n_phase = PH_P0;
                end
                CMD_WRITE: begin
                    n_shift = i_word.write_data; n_bit = 3'd0;
                    n_scl = 1'b0; n_sda = i_word.write_data[7];
                    n_dly = w_dly_load; n_phase = PH_WL;
                end
                CMD_WAIT: begin
                    n_err = 1'b0; n_sda = 1'b1;
                    n_dly = w_dly_load; n_phase = PH_A0;
                end
                CMD_READ: begin
                    n_ackc = i_word.send_ack; n_shift = 8'd0; n_bit = 3'd0;
                    n_scl = 1'b0; n_sda = 1'b1;
                    n_dly = w_dly_load; n_phase = PH_RL;
                end
                default: ;
            endcase
        end else if (r_phase == PH_APOLL) begin
            if (!i_word.sda_in) begin
                n_scl = 1'b0; n_phase = PH_IDLE; w_done = 1'b1;
            end else if (r_poll >= w_lim) begin
                // timeout: release the bus with a stop
                n_err = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                n_dly = w_dly_load; n_phase = PH_P0;
            end else begin
                n_poll = r_poll + t_cnt'(1);
            end
        end else begin
            n_dly = w_dly_dec;
            if (w_dly_dec == '0) begin
                case (r_phase)
                    PH_S0: begin
                        n_sda = 1'b0; n_dly = w_dly_load; n_phase = PH_S1;
                    end
                    PH_S1: begin
                        n_scl = 1'b0; n_phase = PH_IDLE; w_done = 1'b1;
                    end
                    PH_P0: begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_dly = w_dly_load; n_phase = PH_P1;
                    end
                    PH_P1: begin
                        n_phase = PH_IDLE; w_done = 1'b1;
                    end
                    PH_WL: begin
                        n_scl = 1'b1; n_dly = w_dly_load; n_phase = PH_WH;
                    end
                    PH_WH: begin
                        n_scl = 1'b0;
                        if (r_bit == 3'd7) begin
                            n_phase = PH_IDLE; w_done = 1'b1;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_sda   = r_shift[6];
                            n_dly   = w_dly_load; n_phase = PH_WL;
                        end
                    end
                    PH_A0: begin
                        n_scl = 1'b1; n_dly = w_dly_load; n_phase = PH_A1;
                    end
                    PH_A1: begin
                        n_poll = '0; n_phase = PH_APOLL;
                    end
                    PH_RL: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], i_word.sda_in};
                        n_dly   = w_dly_load; n_phase = PH_RH;
                    end
                    PH_RH: begin
                        n_scl = 1'b0;
                        if (r_bit == 3'd7) begin
                            n_last = r_shift;
                            n_sda  = !r_ackc;
                            n_dly  = w_dly_load; n_phase = PH_K0;
                        end else begin
                            n_bit = r_bit + 3'd1;
                            n_dly = w_dly_load; n_phase = PH_RL;
                        end
                    end
                    PH_K0: begin
                        n_scl = 1'b1; n_dly = w_dly_load; n_phase = PH_K1;
                    end
                    PH_K1: begin
                        n_scl = 1'b0; n_phase = PH_IDLE; w_done = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
        w_res.scl_out   = n_scl;
        w_res.sda_out   = n_sda;
        w_res.busy_res  = (n_phase != PH_IDLE);
        w_res.done_res  = w_done;
        w_res.read_data = n_last;
        w_res.ack_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dly   <= '0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_poll  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_err   <= 1'b0;
            r_ackc  <= 1'b0;
            r_last  <= 8'd0;
        end else if (o_word_take) begin
            r_phase <= n_phase;
            r_dly   <= n_dly;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_err   <= n_err;
            r_ackc  <= n_ackc;
            r_last  <= n_last;
        end
    end

    // Two-entry result queue.
    assign empty = (r_qcnt == 2'd0);
    assign w_qrd = pop && !empty;
    assign o_res = r_q[r_qrp];

    always_comb begin
        n_qcnt = r_qcnt;
        if (o_word_take && !w_qrd) begin
            n_qcnt = r_qcnt + 2'd1;
        end else if (w_qrd && !o_word_take) begin
            n_qcnt = r_qcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp  <= 1'b0;
            r_qrp  <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            r_qwp  <= o_word_take ? ~r_qwp : r_qwp;
            r_qrp  <= w_qrd ? ~r_qrp : r_qrp;
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_word_take) begin
            r_q[r_qwp] <= w_res;
        end
    end

endmodule

// File: hw/rtl/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// A pushed word waits in the front queue; the engine steps on it and writes its result into the result queue.
// Throughput: one tick word per cycle unless the result queue is full (single-step bus engine).
// Both sides are two-entry queues, so push and pop may stall independently.
// Reset (synchronous, active low): queues empty, bus released (SCL and SDA high), engine
// idle, read byte and error cleared, half period 10 ticks, ack timeout 250 polls.

module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick word input
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_write_data,
    input  logic       i_send_ack,
    input  logic       i_sda_in,
    // result output
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_data,
    output logic       o_ack_error,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_ACK_POLLS   = 2'd1;

    logic [7:0] r_half;
    logic [7:0] r_ack_lim;
    t_word      w_word;
    logic       w_word_valid;
    logic       w_word_take;
    t_res       w_res;

    // Config writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= 8'd10;
            r_ack_lim <= 8'd250;
        end else if (cfg_valid) begin
            case (i_cfg_index)
                REG_HALF_PERIOD: r_half    <= i_cfg_data;
                REG_ACK_POLLS:   r_ack_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify the command and queue the tick word.
    i2cbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_write_data (i_write_data),
        .i_send_ack   (i_send_ack),
        .i_sda_in     (i_sda_in),
        .o_word       (w_word),
        .o_word_valid (w_word_valid),
        .i_word_take  (w_word_take)
    );

    // Back: bus engine steps once per word and queues the result.
    i2cbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_half       (r_half),
        .i_ack_lim    (r_ack_lim),
        .i_word       (w_word),
        .i_word_valid (w_word_valid),
        .o_word_take  (w_word_take),
        .pop          (pop),
        .empty        (empty),
        .o_res        (w_res)
    );

    assign o_scl_out   = w_res.scl_out;
    assign o_sda_out   = w_res.sda_out;
    assign o_busy_res  = w_res.busy_res;
    assign o_done_res  = w_res.done_res;
    assign o_read_data = w_res.read_data;
    assign o_ack_error = w_res.ack_error;

endmodule
